/* rtl/core/scr_pkg.sv */
// Shared types and constants for the speaker channel remix block.
// No dependencies; used by every module under rtl/core.
package scr_pkg;

  localparam int NCH      = 6;
  localparam int SAMPLE_W = 16;
  localparam int FRAC     = 15;              // Q1.15 samples and gains
  localparam int CNT_W    = 3;               // channel count register width
  localparam int IDX_W    = 2;               // config index width
  localparam int RSUM_W   = SAMPLE_W + 3;    // sum of up to six samples
  localparam int GAIN_W   = 16;
  localparam int SUM_W    = SAMPLE_W + FRAC + 5;
  localparam int Q_W      = SUM_W - FRAC;

  localparam logic signed [GAIN_W-1:0] RSQ_GAIN = GAIN_W'(23170);   // 0.7071 in Q15
  localparam logic signed [SUM_W-1:0]  RND_HALF = SUM_W'(1) <<< (FRAC - 1);

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  localparam logic [IDX_W-1:0] REG_SRC_COUNT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DST_COUNT = IDX_W'(1);

  localparam int IN_W  = 2 * NCH * SAMPLE_W;
  localparam int OUT_W = NCH * SAMPLE_W;

  typedef enum logic [2:0] {
    G_NONE,
    G_ONE,
    G_HALF,
    G_QTR,
    G_RSQ
  } gain_t;

  typedef gain_t [NCH-1:0]     gain_row_t;   // one gain per source channel
  typedef gain_row_t [NCH-1:0] gain_mat_t;   // one row per destination lane

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NCH-1:0]          frame_t;

endpackage

/* rtl/core/scr_dec.sv */
// Gain matrix decoder: maps source/target channel counts to per-lane gains.
// Depends on scr_pkg.
module scr_dec (
  input  logic [scr_pkg::CNT_W-1:0] src_count,
  input  logic [scr_pkg::CNT_W-1:0] dst_count,
  output scr_pkg::gain_mat_t        gains
);

  logic [scr_pkg::CNT_W-1:0] n_disc;

  assign n_disc = (src_count < dst_count) ? src_count : dst_count;

  always_comb begin
    for (int d = 0; d < scr_pkg::NCH; d++) begin
      for (int s = 0; s < scr_pkg::NCH; s++) begin
        gains[d][s] = scr_pkg::G_NONE;
      end
    end
    case ({src_count, dst_count})
      {3'd1, 3'd2}, {3'd1, 3'd4}: begin
        gains[0][0] = scr_pkg::G_ONE;
        gains[1][0] = scr_pkg::G_ONE;
      end
      {3'd1, 3'd6}: begin
        gains[2][0] = scr_pkg::G_ONE;
      end
      {3'd2, 3'd1}: begin
        gains[0][0] = scr_pkg::G_HALF;
        gains[0][1] = scr_pkg::G_HALF;
      end
      {3'd2, 3'd4}, {3'd2, 3'd6}: begin
        gains[0][0] = scr_pkg::G_ONE;
        gains[1][1] = scr_pkg::G_ONE;
      end
      {3'd4, 3'd1}: begin
        for (int s = 0; s < 4; s++) begin
          gains[0][s] = scr_pkg::G_QTR;
        end
      end
      {3'd4, 3'd2}: begin
        gains[0][0] = scr_pkg::G_HALF;
        gains[0][2] = scr_pkg::G_HALF;
        gains[1][1] = scr_pkg::G_HALF;
        gains[1][3] = scr_pkg::G_HALF;
      end
      {3'd4, 3'd6}: begin
        gains[0][0] = scr_pkg::G_ONE;
        gains[1][1] = scr_pkg::G_ONE;
        gains[4][2] = scr_pkg::G_ONE;
        gains[5][3] = scr_pkg::G_ONE;
      end
      {3'd6, 3'd1}: begin
        gains[0][0] = scr_pkg::G_RSQ;
        gains[0][1] = scr_pkg::G_RSQ;
        gains[0][2] = scr_pkg::G_ONE;
        gains[0][4] = scr_pkg::G_HALF;
        gains[0][5] = scr_pkg::G_HALF;
      end
      {3'd6, 3'd2}: begin
        gains[0][0] = scr_pkg::G_ONE;
        gains[0][2] = scr_pkg::G_RSQ;
        gains[0][4] = scr_pkg::G_RSQ;
        gains[1][1] = scr_pkg::G_ONE;
        gains[1][2] = scr_pkg::G_RSQ;
        gains[1][5] = scr_pkg::G_RSQ;
      end
      {3'd6, 3'd4}: begin
        gains[0][0] = scr_pkg::G_ONE;
        gains[0][2] = scr_pkg::G_RSQ;
        gains[1][1] = scr_pkg::G_ONE;
        gains[1][2] = scr_pkg::G_RSQ;
        gains[2][4] = scr_pkg::G_ONE;
        gains[3][5] = scr_pkg::G_ONE;
      end
      default: begin
        // discrete: channel c into channel c below the smaller count
        for (int c = 0; c < scr_pkg::NCH; c++) begin
          if (c < int'(n_disc)) gains[c][c] = scr_pkg::G_ONE;
        end
      end
    endcase
  end

endmodule

/* rtl/core/scr_lane.sv */
// One destination-channel lane: gather stage, then 0.7071 multiply,
// round and saturate. Depends on scr_pkg.
module scr_lane (
  input  logic               clk,
  input  logic               load,        // request accepted into stage 1
  input  scr_pkg::frame_t    src,
  input  scr_pkg::sample_t   acc,
  input  scr_pkg::gain_row_t gains,
  output scr_pkg::sample_t   mix
);

  localparam int EXT_W = scr_pkg::SUM_W - scr_pkg::SAMPLE_W;

  logic signed [scr_pkg::SUM_W-1:0]  plain_nxt, plain_r;
  logic signed [scr_pkg::RSUM_W-1:0] rsum_nxt, rsum_r;
  logic signed [scr_pkg::SUM_W-1:0]  ext;
  logic signed [scr_pkg::RSUM_W+scr_pkg::GAIN_W-1:0] prod;
  logic signed [scr_pkg::SUM_W-1:0]  total;
  logic signed [scr_pkg::Q_W-1:0]    q;

  localparam logic signed [scr_pkg::Q_W-1:0] Q_MAX =
    scr_pkg::Q_W'((1 << (scr_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [scr_pkg::Q_W-1:0] Q_MIN = -Q_MAX - scr_pkg::Q_W'(1);

  // stage 1: unity / half / quarter terms as shifts, 0.7071 terms pre-summed
  always_comb begin
    ext       = '0;
    plain_nxt = {{EXT_W{acc[scr_pkg::SAMPLE_W-1]}}, acc} <<< scr_pkg::FRAC;
    rsum_nxt  = '0;
    for (int s = 0; s < scr_pkg::NCH; s++) begin
      ext = {{EXT_W{src[s][scr_pkg::SAMPLE_W-1]}}, src[s]};
      case (gains[s])
        scr_pkg::G_ONE:  plain_nxt = plain_nxt + (ext <<< scr_pkg::FRAC);
        scr_pkg::G_HALF: plain_nxt = plain_nxt + (ext <<< (scr_pkg::FRAC - 1));
        scr_pkg::G_QTR:  plain_nxt = plain_nxt + (ext <<< (scr_pkg::FRAC - 2));
        scr_pkg::G_RSQ:  rsum_nxt  = rsum_nxt + ext[scr_pkg::RSUM_W-1:0];
        default:         plain_nxt = plain_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plain_r <= plain_nxt;
      rsum_r  <= rsum_nxt;
    end
  end

  // stage 2: one constant multiply, add, round half up, saturate
  always_comb begin
    prod  = rsum_r * scr_pkg::RSQ_GAIN;
    total = plain_r + scr_pkg::SUM_W'(prod) + scr_pkg::RND_HALF;
    q     = total[scr_pkg::SUM_W-1:scr_pkg::FRAC];
    if (q > Q_MAX)      mix = Q_MAX[scr_pkg::SAMPLE_W-1:0];
    else if (q < Q_MIN) mix = Q_MIN[scr_pkg::SAMPLE_W-1:0];
    else                mix = q[scr_pkg::SAMPLE_W-1:0];
  end

endmodule

/* rtl/core/scr_out.sv */
// Output stage: merges the six lane results into one registered frame.
// Depends on scr_pkg.
module scr_out (
  input  logic                       clk,
  input  logic                       load,
  input  scr_pkg::frame_t            mix,
  output logic [scr_pkg::OUT_W-1:0]  tdata
);

  logic [scr_pkg::OUT_W-1:0] data_r, data_nxt;

  always_comb begin
    for (int c = 0; c < scr_pkg::NCH; c++) begin
      data_nxt[c*scr_pkg::SAMPLE_W +: scr_pkg::SAMPLE_W] = mix[c];
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= data_nxt;
  end

  assign tdata = data_r;

endmodule

/* rtl/core/speaker_channel_remix.sv */
// Speaker channel remix: up/down mixes one six-channel frame per request.
// Depends on scr_pkg, scr_dec, scr_lane and scr_out.
//
// Usage
//   in_*  : one frame per request. tdata holds src_0..src_5 then
//           acc_in_0..acc_in_5, 16-bit signed Q1.15 each, lowest first.
//   out_* : one mixed frame per request, mix_0..mix_5, lowest first.
//   cfg_* : register writes, always ready. Index 0 is the source channel
//           count, index 1 the target count; other indexes are dropped.
//           Write only while the block is empty.
// Timing
//   A frame passes from input acceptance to out_tvalid through a gather
//   stage in each of the six lanes, then the 0.7071 multiply, rounding and
//   saturation feeding the output register. Throughput is one frame per
//   cycle when not stalled; the one multiplier per lane sets the stage split.
// Reset
//   rst_n (synchronous, active low) empties both stages and sets both
//   channel counts to 2 (stereo to stereo, discrete copy).
// Back-pressure
//   With out_tready low the output frame holds; the gather stage still
//   takes one more frame, then in_tready drops until the output drains.
module speaker_channel_remix (
  input  logic                              clk,
  input  logic                              rst_n,
  // src_0..src_5, acc_in_0..acc_in_5 (16 bits each, from bit 0 up)
  input  logic [scr_pkg::IN_W-1:0]          in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mix_0..mix_5 (16 bits each, from bit 0 up)
  output logic [scr_pkg::OUT_W-1:0]         out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scr_pkg::IDX_W-1:0]         cfg_index,
  input  logic [scr_pkg::CNT_W-1:0]         cfg_data
);

  logic [scr_pkg::CNT_W-1:0] src_count_r, src_count_nxt;
  logic [scr_pkg::CNT_W-1:0] dst_count_r, dst_count_nxt;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      in_fire, out_adv, out_load;

  scr_pkg::gain_mat_t gains;
  scr_pkg::frame_t    src, acc, mix;

  assign cfg_ready = 1'b1;

  // config registers
  always_comb begin
    src_count_nxt = src_count_r;
    dst_count_nxt = dst_count_r;
    if (cfg_valid) begin
      case (cfg_index)
        scr_pkg::REG_SRC_COUNT: src_count_nxt = cfg_data;
        scr_pkg::REG_DST_COUNT: dst_count_nxt = cfg_data;
        default:                src_count_nxt = src_count_r;
      endcase
    end
  end

  // unpack request
  always_comb begin
    for (int c = 0; c < scr_pkg::NCH; c++) begin
      src[c] = in_tdata[c*scr_pkg::SAMPLE_W +: scr_pkg::SAMPLE_W];
      acc[c] = in_tdata[(scr_pkg::NCH + c)*scr_pkg::SAMPLE_W +: scr_pkg::SAMPLE_W];
    end
  end

  // two-stage flow control: output register frees the gather stage
  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = s1_valid_r && out_adv;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (out_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_count_r <= scr_pkg::CNT_RESET;
      dst_count_r <= scr_pkg::CNT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      src_count_r <= src_count_nxt;
      dst_count_r <= dst_count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  scr_dec u_dec (
    .src_count (src_count_r),
    .dst_count (dst_count_r),
    .gains     (gains)
  );

  // one lane per destination channel
  for (genvar d = 0; d < scr_pkg::NCH; d++) begin : g_lane
    scr_lane u_lane (
      .clk   (clk),
      .load  (in_fire),
      .src   (src),
      .acc   (acc[d]),
      .gains (gains[d]),
      .mix   (mix[d])
    );
  end

  scr_out u_out (
    .clk   (clk),
    .load  (out_load),
    .mix   (mix),
    .tdata (out_tdata)
  );

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/core/scr_chk.sv */
// Port-level checker for speaker_channel_remix, attached by bind.
// Depends on scr_pkg and speaker_channel_remix.
module scr_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [scr_pkg::OUT_W-1:0]     out_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready
);

  // nothing comes out straight after reset
  a_rst_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  // out_tvalid is high after an accepted request passes the gather and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("result missing two cycles after request");

  // an empty output side never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind speaker_channel_remix scr_chk u_chk (.*);
